FILE: design/slafe_pkg.sv
// Package for the serial link acknowledge flow engine.
// Holds the default ring depths, line word constants and the command word
// that the front end hands to the back end. No dependencies.
`default_nettype none

package slafe_pkg;

    // Default ring depths. Each ring keeps one slot unused.
    localparam int RX_DEPTH_DEF = 256;
    localparam int TX_DEPTH_DEF = 256;

    // Word sent on the line as an acknowledge.
    localparam logic [8:0] ACK_WORD = 9'h1FF;

    // Byte returned by a read of an empty receive ring.
    localparam logic [7:0] EMPTY_READ_BYTE = 8'hFF;

    // Saturation limit of the acknowledge counter and the level output.
    localparam logic [7:0] COUNT_MAX = 8'hFF;

    // Input mode codes.
    localparam logic [1:0] MODE_LINE  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_TICK  = 2'd3;

    // Command kinds after classification.
    localparam logic [2:0] CMD_ACK   = 3'd0;
    localparam logic [2:0] CMD_DATA  = 3'd1;
    localparam logic [2:0] CMD_WRITE = 3'd2;
    localparam logic [2:0] CMD_READ  = 3'd3;
    localparam logic [2:0] CMD_TICK  = 3'd4;

    // Depth of the command queue between front and back end.
    localparam int CMDQ_DEPTH = 2;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
    } cmd_t;

endpackage

`default_nettype wire

FILE: design/slafe_ram.sv
// Generic single write port, single read port RAM with registered read.
// Used for both byte rings. No dependencies.
`default_nettype none

module slafe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: design/slafe_front.sv
// Front end: accepts input words, classifies them into commands and holds
// them in a short queue for the back end. Depends on slafe_pkg.
`default_nettype none

module slafe_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        mode,
    input  wire logic [8:0]        line_word,
    input  wire logic [7:0]        host_byte,
    output logic                   q_valid,
    output slafe_pkg::cmd_t        q_cmd,
    input  wire logic              q_pop
);

    localparam int QAW = $clog2(slafe_pkg::CMDQ_DEPTH);
    localparam int QCW = $clog2(slafe_pkg::CMDQ_DEPTH + 1);

    slafe_pkg::cmd_t cmd_in;
    slafe_pkg::cmd_t q_mem_reg [slafe_pkg::CMDQ_DEPTH];
    logic [QAW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]  cnt_reg, cnt_next;
    logic            push;
    logic            pop;

    // A line word is inverted on the wire; its low bit clear after inversion
    // marks an acknowledge, otherwise the upper eight bits carry the data.
    always_comb
    begin
        cmd_in.data = 8'h00;
        case (mode)
            slafe_pkg::MODE_LINE:
            begin
                if (line_word[0])
                begin
                    cmd_in.kind = slafe_pkg::CMD_ACK;
                end
                else
                begin
                    cmd_in.kind = slafe_pkg::CMD_DATA;
                    cmd_in.data = ~line_word[8:1];
                end
            end
            slafe_pkg::MODE_WRITE:
            begin
                cmd_in.kind = slafe_pkg::CMD_WRITE;
                cmd_in.data = host_byte;
            end
            slafe_pkg::MODE_READ:
            begin
                cmd_in.kind = slafe_pkg::CMD_READ;
            end
            default:
            begin
                cmd_in.kind = slafe_pkg::CMD_TICK;
            end
        endcase
    end

    assign in_stall = (cnt_reg == QCW'(slafe_pkg::CMDQ_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_cmd    = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(slafe_pkg::CMDQ_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + QAW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(slafe_pkg::CMDQ_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + QAW'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QCW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

FILE: design/slafe_back.sv
// Back end: executes commands against the receive and transmit rings and the
// acknowledge state, and drives the output word register.
// Depends on slafe_pkg and slafe_ram.
`default_nettype none

module slafe_back #(
    parameter int RX_DEPTH = slafe_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = slafe_pkg::TX_DEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_valid,
    input  wire slafe_pkg::cmd_t  q_cmd,
    output logic                  q_pop,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic                  line_send_valid,
    output logic [8:0]            line_send_word,
    output logic                  read_valid,
    output logic [7:0]            read_byte,
    output logic                  write_accepted,
    output logic [7:0]            rx_level,
    output logic                  tx_is_empty,
    output logic                  awaiting_ack
);

    localparam int RXW = $clog2(RX_DEPTH);
    localparam int TXW = $clog2(TX_DEPTH);
    localparam int CW  = RXW + 1;
    localparam int LW  = (CW > 8) ? CW : 8;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RESP = 1'b1;

    logic           st_reg, st_next;
    logic [RXW-1:0] rx_head_reg, rx_head_next;
    logic [RXW-1:0] rx_tail_reg, rx_tail_next;
    logic [TXW-1:0] tx_head_reg, tx_head_next;
    logic [TXW-1:0] tx_tail_reg, tx_tail_next;
    logic           held_ack_reg, held_ack_next;
    logic [7:0]     ack_count_reg, ack_count_next;
    logic           tx_full_reg, tx_full_next;
    logic           wait_ack_reg, wait_ack_next;

    // Per-item flags carried from the execute cycle to the response cycle.
    logic           p_send_ack_reg, p_send_ack_next;
    logic           p_send_data_reg, p_send_data_next;
    logic           p_rd_ok_reg, p_rd_ok_next;
    logic           p_rd_empty_reg, p_rd_empty_next;
    logic           p_wr_ok_reg, p_wr_ok_next;

    logic           out_valid_reg;
    logic           go;

    logic [RXW-1:0] rx_nh, rx_nnh, rx_nt;
    logic [TXW-1:0] tx_nh, tx_nt;
    logic           rx_we, rx_re, tx_we, tx_re;
    logic [7:0]     rx_rdata, tx_rdata;
    logic [CW-1:0]  rx_cnt;
    logic [LW-1:0]  rx_cnt_ext;

    assign go    = (st_reg == ST_IDLE) && q_valid && (!out_valid_reg || !out_stall);
    assign q_pop = go;

    assign rx_nh  = (rx_head_reg == RXW'(RX_DEPTH - 1)) ? '0 : rx_head_reg + RXW'(1);
    assign rx_nnh = (rx_nh == RXW'(RX_DEPTH - 1)) ? '0 : rx_nh + RXW'(1);
    assign rx_nt  = (rx_tail_reg == RXW'(RX_DEPTH - 1)) ? '0 : rx_tail_reg + RXW'(1);
    assign tx_nh  = (tx_head_reg == TXW'(TX_DEPTH - 1)) ? '0 : tx_head_reg + TXW'(1);
    assign tx_nt  = (tx_tail_reg == TXW'(TX_DEPTH - 1)) ? '0 : tx_tail_reg + TXW'(1);

    always_comb
    begin
        st_next          = st_reg;
        rx_head_next     = rx_head_reg;
        rx_tail_next     = rx_tail_reg;
        tx_head_next     = tx_head_reg;
        tx_tail_next     = tx_tail_reg;
        held_ack_next    = held_ack_reg;
        ack_count_next   = ack_count_reg;
        tx_full_next     = tx_full_reg;
        wait_ack_next    = wait_ack_reg;
        p_send_ack_next  = p_send_ack_reg;
        p_send_data_next = p_send_data_reg;
        p_rd_ok_next     = p_rd_ok_reg;
        p_rd_empty_next  = p_rd_empty_reg;
        p_wr_ok_next     = p_wr_ok_reg;
        rx_we            = 1'b0;
        rx_re            = 1'b0;
        tx_we            = 1'b0;
        tx_re            = 1'b0;

        if (go)
        begin
            st_next          = ST_RESP;
            p_send_ack_next  = 1'b0;
            p_send_data_next = 1'b0;
            p_rd_ok_next     = 1'b0;
            p_rd_empty_next  = 1'b0;
            p_wr_ok_next     = 1'b0;
            case (q_cmd.kind)
                slafe_pkg::CMD_ACK:
                begin
                    if (ack_count_reg != slafe_pkg::COUNT_MAX)
                    begin
                        ack_count_next = ack_count_reg + 8'd1;
                    end
                end
                slafe_pkg::CMD_DATA:
                begin
                    if (rx_nh == rx_tail_reg)
                    begin
                        held_ack_next = 1'b1;
                    end
                    else
                    begin
                        rx_we        = 1'b1;
                        rx_head_next = rx_nh;
                        if (rx_nnh == rx_tail_reg)
                        begin
                            held_ack_next = 1'b1;
                        end
                        else
                        begin
                            held_ack_next   = 1'b0;
                            p_send_ack_next = 1'b1;
                        end
                    end
                end
                slafe_pkg::CMD_WRITE:
                begin
                    if (!tx_full_reg)
                    begin
                        if (tx_nh == tx_tail_reg)
                        begin
                            tx_full_next = 1'b1;
                        end
                        else
                        begin
                            tx_we        = 1'b1;
                            tx_head_next = tx_nh;
                            p_wr_ok_next = 1'b1;
                        end
                    end
                end
                slafe_pkg::CMD_READ:
                begin
                    if (rx_head_reg == rx_tail_reg)
                    begin
                        p_rd_empty_next = 1'b1;
                    end
                    else
                    begin
                        rx_re        = 1'b1;
                        rx_tail_next = rx_nt;
                        p_rd_ok_next = 1'b1;
                        if (held_ack_reg)
                        begin
                            p_send_ack_next = 1'b1;
                            held_ack_next   = 1'b0;
                        end
                    end
                end
                default:
                begin
                    if (wait_ack_reg)
                    begin
                        if (ack_count_reg != 8'd0)
                        begin
                            ack_count_next = ack_count_reg - 8'd1;
                            wait_ack_next  = 1'b0;
                        end
                    end
                    else if (tx_head_reg != tx_tail_reg)
                    begin
                        tx_re            = 1'b1;
                        tx_tail_next     = tx_nt;
                        tx_full_next     = 1'b0;
                        p_send_data_next = 1'b1;
                        wait_ack_next    = 1'b1;
                    end
                end
            endcase
        end
        else if (st_reg == ST_RESP)
        begin
            st_next = ST_IDLE;
        end
    end

    slafe_ram #(
        .WIDTH (8),
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_head_reg),
        .wdata (q_cmd.data),
        .re    (rx_re),
        .raddr (rx_tail_reg),
        .rdata (rx_rdata)
    );

    slafe_ram #(
        .WIDTH (8),
        .DEPTH (TX_DEPTH)
    ) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_head_reg),
        .wdata (q_cmd.data),
        .re    (tx_re),
        .raddr (tx_tail_reg),
        .rdata (tx_rdata)
    );

    // Receive ring fill level from the already updated pointers.
    assign rx_cnt = CW'(rx_head_reg) - CW'(rx_tail_reg) +
                    ((rx_head_reg < rx_tail_reg) ? CW'(RX_DEPTH) : '0);
    assign rx_cnt_ext = LW'(rx_cnt);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            rx_head_reg   <= '0;
            rx_tail_reg   <= '0;
            tx_head_reg   <= '0;
            tx_tail_reg   <= '0;
            held_ack_reg  <= 1'b0;
            ack_count_reg <= '0;
            tx_full_reg   <= 1'b0;
            wait_ack_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            rx_head_reg   <= rx_head_next;
            rx_tail_reg   <= rx_tail_next;
            tx_head_reg   <= tx_head_next;
            tx_tail_reg   <= tx_tail_next;
            held_ack_reg  <= held_ack_next;
            ack_count_reg <= ack_count_next;
            tx_full_reg   <= tx_full_next;
            wait_ack_reg  <= wait_ack_next;
            if (st_reg == ST_RESP)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_send_ack_reg  <= p_send_ack_next;
        p_send_data_reg <= p_send_data_next;
        p_rd_ok_reg     <= p_rd_ok_next;
        p_rd_empty_reg  <= p_rd_empty_next;
        p_wr_ok_reg     <= p_wr_ok_next;
        if (st_reg == ST_RESP)
        begin
            line_send_valid <= p_send_ack_reg || p_send_data_reg;
            if (p_send_data_reg)
            begin
                line_send_word <= {~tx_rdata, 1'b0};
            end
            else if (p_send_ack_reg)
            begin
                line_send_word <= slafe_pkg::ACK_WORD;
            end
            else
            begin
                line_send_word <= 9'h000;
            end
            read_valid <= p_rd_ok_reg;
            if (p_rd_ok_reg)
            begin
                read_byte <= rx_rdata;
            end
            else if (p_rd_empty_reg)
            begin
                read_byte <= slafe_pkg::EMPTY_READ_BYTE;
            end
            else
            begin
                read_byte <= 8'h00;
            end
            write_accepted <= p_wr_ok_reg;
            rx_level       <= (rx_cnt_ext > LW'(slafe_pkg::COUNT_MAX)) ?
                              slafe_pkg::COUNT_MAX : rx_cnt_ext[7:0];
            tx_is_empty    <= (tx_head_reg == tx_tail_reg);
            awaiting_ack   <= wait_ack_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: design/serial_link_ack_flow_engine.sv
// Top level of the serial link acknowledge flow engine.
// Instantiates slafe_front and slafe_back; depends on slafe_pkg.
//
//  Channel  Handshake            Payload
//  -------  -------------------  -------------------------------------------
//  input    in_valid / in_stall   mode, line_word, host_byte
//  output   out_valid / out_stall line_send_valid, line_send_word, read_valid,
//                                 read_byte, write_accepted, rx_level,
//                                 tx_is_empty, awaiting_ack
//
// Each word passes the back end in an execute step, which updates the ring pointers
// and flags and starts the ring read, and a response step, which takes the registered
// read data of the ring RAM and loads the output register. The back end takes no new
// word until the response step of the last word is done.
// Reset (rst_n, asynchronous, active low) empties both rings and clears the
// acknowledge state; the ring RAMs need no clearing pass.
// The input side stalls only when the two-entry command queue is full, so it
// keeps taking words while a result waits on a stalled output.
`default_nettype none

module serial_link_ack_flow_engine #(
    parameter int RX_DEPTH = slafe_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = slafe_pkg::TX_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] mode,
    input  wire logic [8:0] line_word,
    input  wire logic [7:0] host_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            line_send_valid,
    output logic [8:0]      line_send_word,
    output logic            read_valid,
    output logic [7:0]      read_byte,
    output logic            write_accepted,
    output logic [7:0]      rx_level,
    output logic            tx_is_empty,
    output logic            awaiting_ack
);

    // Classified command word handed from the front end to the back end.
    slafe_pkg::cmd_t q_cmd;
    logic            q_valid;
    logic            q_pop;

    // The front end inverts and classifies line words and queues every word
    // as a command, so input acceptance never waits on the rings.
    slafe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .line_word (line_word),
        .host_byte (host_byte),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop)
    );

    // The back end owns both rings, the held acknowledge and the acknowledge
    // counter, and pops a command only when the output register is free or
    // draining, so no result is ever overwritten.
    slafe_back #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_cmd           (q_cmd),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .line_send_valid (line_send_valid),
        .line_send_word  (line_send_word),
        .read_valid      (read_valid),
        .read_byte       (read_byte),
        .write_accepted  (write_accepted),
        .rx_level        (rx_level),
        .tx_is_empty     (tx_is_empty),
        .awaiting_ack    (awaiting_ack)
    );

endmodule

`default_nettype wire

FILE: design/slafe_chk.sv
// Port-level checker for the serial link acknowledge flow engine, bound to
// the top level. Depends on slafe_pkg and serial_link_ack_flow_engine.
`default_nettype none

module slafe_chk (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic       line_send_valid,
    input wire logic [8:0] line_send_word,
    input wire logic       read_valid,
    input wire logic       write_accepted,
    input wire logic       tx_is_empty,
    input wire logic       awaiting_ack
);

    // A stalled output word stays valid and holds its line word.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(line_send_word))
        else $error("output word changed while stalled");

    // No line word is shown unless one is sent.
    a_idle_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !line_send_valid |-> line_send_word == 9'h000)
        else $error("line word without send");

    // A read and a write are never reported by the same word.
    a_rd_wr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_valid |-> !write_accepted)
        else $error("read and write in one word");

    // A queued byte leaves the transmit ring nonempty.
    a_wr_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_accepted |-> !tx_is_empty)
        else $error("accepted write but transmit ring empty");

    // Sending a data byte always starts a wait for its acknowledge.
    a_data_wait: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_send_valid && line_send_word != slafe_pkg::ACK_WORD
        |-> awaiting_ack && !line_send_word[0])
        else $error("data byte sent without waiting for acknowledge");

endmodule

bind serial_link_ack_flow_engine slafe_chk u_slafe_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .line_send_valid (line_send_valid),
    .line_send_word  (line_send_word),
    .read_valid      (read_valid),
    .write_accepted  (write_accepted),
    .tx_is_empty     (tx_is_empty),
    .awaiting_ack    (awaiting_ack)
);

`default_nettype wire

FILE: tb/serial_link_ack_flow_engine_test.sv
// Testbench for serial_link_ack_flow_engine: drives line, host and tick words with random
// idling on both channels and checks every result word against a local model or a table row.
// Depends on slafe_pkg and the design under test; needs nothing else.

module serial_link_ack_flow_engine_test;

    // Run shape. The directed table comes first; the random part then runs segments
    // until the word count is reached and every burst kind has been seen.
    localparam int RANDOM_WORDS = 680;
    localparam int LAST_SEG     = 6;
    localparam int RX_FILL_SEG  = 1;
    localparam int TX_FILL_SEG  = 3;
    localparam int ACK_SEG      = 5;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 20;
    localparam int CYCLE_LIMIT  = 500000;

    // One result word of the block, field by field.
    typedef struct packed {
        logic       send_v;
        logic [8:0] send_w;
        logic       rd_v;
        logic [7:0] rd_b;
        logic       wr_ok;
        logic [7:0] level;
        logic       tx_empty;
        logic       awaiting;
    } link_out_t;

    // One row of the directed table. Where typed is set, want holds the result that
    // the row must give; other rows are checked against the model.
    typedef struct packed {
        logic [1:0] m;
        logic [8:0] lw;
        logic [7:0] hb;
        logic       typed;
        link_out_t  want;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] mode = slafe_pkg::MODE_LINE;
    logic [8:0] line_word = '0;
    logic [7:0] host_byte = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       line_send_valid;
    logic [8:0] line_send_word;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       write_accepted;
    logic [7:0] rx_level;
    logic       tx_is_empty;
    logic       awaiting_ack;

    serial_link_ack_flow_engine uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .mode            (mode),
        .line_word       (line_word),
        .host_byte       (host_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .line_send_valid (line_send_valid),
        .line_send_word  (line_send_word),
        .read_valid      (read_valid),
        .read_byte       (read_byte),
        .write_accepted  (write_accepted),
        .rx_level        (rx_level),
        .tx_is_empty     (tx_is_empty),
        .awaiting_ack    (awaiting_ack)
    );

    always #5 clk = ~clk;

    // Model state of the link. Both rings have 256 slots, so the 8-bit pointers wrap
    // on their own and one slot always stays free. Ring entries are only read after
    // they were written, so the memories need no reset.
    logic [7:0] rx_mem [256];
    logic [7:0] tx_mem [256];
    logic [7:0] rx_wp = '0;
    logic [7:0] rx_rp = '0;
    logic [7:0] tx_wp = '0;
    logic [7:0] tx_rp = '0;
    logic [7:0] acks_pending = '0;
    logic       ack_held = 1'b0;
    logic       tx_blocked = 1'b0;
    logic       tx_waiting = 1'b0;

    // Results that accepted words have caused and that have not come out yet.
    link_out_t  link_out_due [$];
    stim_row_t  dir_rows [$];

    int         fails = 0;
    int         words_sent = 0;
    int         cycle_count = 0;
    bit         no_gaps = 1'b0;
    bit         hold_off_req = 1'b0;
    link_out_t  got_due;

    // Applies one input word to the model state and returns the result it causes.
    function automatic link_out_t predict_link_step(logic [1:0] m, logic [8:0] lw,
                                                    logic [7:0] hb);
        link_out_t  r;
        logic [8:0] msg;
        logic [7:0] nxt;
        logic [7:0] d;
        r = '0;
        case (m)
            slafe_pkg::MODE_LINE:
            begin
                // The line carries inverted words; bit 0 of the true word marks data.
                msg = ~lw;
                if (!msg[0])
                begin
                    if (acks_pending != slafe_pkg::COUNT_MAX)
                        acks_pending = acks_pending + 8'd1;
                end
                else
                begin
                    nxt = rx_wp + 8'd1;
                    if (nxt == rx_rp)
                        ack_held = 1'b1;    // ring full: the byte is lost
                    else
                    begin
                        rx_mem[rx_wp] = msg[8:1];
                        rx_wp = nxt;
                        nxt = rx_wp + 8'd1;
                        if (nxt == rx_rp)
                            ack_held = 1'b1;    // only the spare slot is left
                        else
                        begin
                            ack_held = 1'b0;
                            r.send_v = 1'b1;
                            r.send_w = slafe_pkg::ACK_WORD;
                        end
                    end
                end
            end
            slafe_pkg::MODE_WRITE:
            begin
                if (!tx_blocked)
                begin
                    nxt = tx_wp + 8'd1;
                    if (nxt == tx_rp)
                        tx_blocked = 1'b1;
                    else
                    begin
                        tx_mem[tx_wp] = hb;
                        tx_wp = nxt;
                        r.wr_ok = 1'b1;
                    end
                end
            end
            slafe_pkg::MODE_READ:
            begin
                if (rx_wp == rx_rp)
                    r.rd_b = slafe_pkg::EMPTY_READ_BYTE;
                else
                begin
                    r.rd_v = 1'b1;
                    r.rd_b = rx_mem[rx_rp];
                    rx_rp = rx_rp + 8'd1;
                    if (ack_held)
                    begin
                        r.send_v = 1'b1;
                        r.send_w = slafe_pkg::ACK_WORD;
                        ack_held = 1'b0;
                    end
                end
            end
            default:
            begin
                // Transmit tick: either close the wait with a received acknowledge or
                // send the next queued byte and start waiting.
                if (tx_waiting)
                begin
                    if (acks_pending != 8'd0)
                    begin
                        acks_pending = acks_pending - 8'd1;
                        tx_waiting = 1'b0;
                    end
                end
                else if (tx_wp != tx_rp)
                begin
                    d = tx_mem[tx_rp];
                    tx_rp = tx_rp + 8'd1;
                    tx_blocked = 1'b0;
                    r.send_v = 1'b1;
                    r.send_w = {~d, 1'b0};
                    tx_waiting = 1'b1;
                end
            end
        endcase
        r.level = rx_wp - rx_rp;
        r.tx_empty = (tx_wp == tx_rp);
        r.awaiting = tx_waiting;
        return r;
    endfunction

    function automatic link_out_t mk_out(logic sv, logic [8:0] sw, logic rv, logic [7:0] rb,
                                         logic wr, logic [7:0] lvl, logic te, logic aw);
        link_out_t r;
        r = '{sv, sw, rv, rb, wr, lvl, te, aw};
        return r;
    endfunction

    // Idle cycles before the next word on either side; none in segments run without gaps.
    function automatic int draw_gap();
        int n;
        n = no_gaps ? 0 : $urandom_range(0, 16);
        return n;
    endfunction

    function automatic void check_field(string name, logic [8:0] want, logic [8:0] got);
        if (want !== got)
        begin
            fails++;
            $error("%s: expected %0h, actual %0h", name, want, got);
        end
    endfunction

    // Offers one word after a random gap and holds it until the block takes it. Valid
    // stays high into the next word when there is no gap, so it is driven only once
    // per falling edge.
    task automatic offer_word(input logic [1:0] m, input logic [8:0] lw, input logic [7:0] hb,
                              input logic typed, input link_out_t want);
        int        gap;
        link_out_t p;
        gap = draw_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        mode      <= m;
        line_word <= lw;
        host_byte <= hb;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        p = predict_link_step(m, lw, hb);
        link_out_due.push_back(typed ? want : p);
        words_sent++;
    endtask

    // A word of any kind with every field random; used for mixed traffic.
    task automatic offer_mixed();
        int         pick;
        logic [1:0] m;
        logic [8:0] lw;
        logic [7:0] hb;
        pick = $urandom_range(0, 99);
        lw = 9'($urandom_range(0, 511));
        hb = 8'($urandom_range(0, 255));
        if (pick < 35)
            m = slafe_pkg::MODE_LINE;
        else if (pick < 55)
            m = slafe_pkg::MODE_WRITE;
        else if (pick < 80)
            m = slafe_pkg::MODE_READ;
        else
            m = slafe_pkg::MODE_TICK;
        offer_word(m, lw, hb, 1'b0, '0);
    endtask

    // Drops valid right after the last accepted word, so nothing is taken twice, and
    // waits until every outstanding result has come out.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (link_out_due.size() != 0)
            @(posedge clk);
    endtask

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: every accepted result word is matched against the oldest due one.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (link_out_due.size() == 0)
            begin
                fails++;
                $error("result word with none due");
            end
            else
            begin
                got_due = link_out_due.pop_front();
                check_field("line_send_valid", 9'(got_due.send_v), 9'(line_send_valid));
                check_field("line_send_word", got_due.send_w, line_send_word);
                check_field("read_valid", 9'(got_due.rd_v), 9'(read_valid));
                check_field("read_byte", 9'(got_due.rd_b), 9'(read_byte));
                check_field("write_accepted", 9'(got_due.wr_ok), 9'(write_accepted));
                check_field("rx_level", 9'(got_due.level), 9'(rx_level));
                check_field("tx_is_empty", 9'(got_due.tx_empty), 9'(tx_is_empty));
                check_field("awaiting_ack", 9'(got_due.awaiting), 9'(awaiting_ack));
            end
        end
    end

    // Result side stall: a random hold-off before each result word, or a long one on
    // request so that the command queue fills and the input side has to stall.
    initial
    begin : result_side
        int n;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off_req)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                n = draw_gap();
                if (n > 0)
                begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                    repeat (n - 1) @(negedge clk);
                end
            end
            @(negedge clk);
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin : word_side
        int         seg;
        int         len;
        int         k;
        logic [8:0] lw;
        logic [7:0] hb;
        stim_row_t  row;

        // Directed table. It starts from reset, touches the empty read, the idle tick,
        // both forms of acknowledge, the extreme data bytes, the wait for an
        // acknowledge that has not come, and the wait that ends on one.
        dir_rows.push_back('{slafe_pkg::MODE_READ, 9'h000, 8'h00, 1'b1,
                             mk_out(0, 9'h000, 0, slafe_pkg::EMPTY_READ_BYTE, 0, 8'd0, 1, 0)});
        dir_rows.push_back('{slafe_pkg::MODE_TICK, 9'h000, 8'h00, 1'b1,
                             mk_out(0, 9'h000, 0, 8'h00, 0, 8'd0, 1, 0)});
        dir_rows.push_back('{slafe_pkg::MODE_LINE, 9'h1FF, 8'h00, 1'b1,
                             mk_out(0, 9'h000, 0, 8'h00, 0, 8'd0, 1, 0)});
        dir_rows.push_back('{slafe_pkg::MODE_LINE, 9'h000, 8'h00, 1'b1,
                             mk_out(1, slafe_pkg::ACK_WORD, 0, 8'h00, 0, 8'd1, 1, 0)});
        dir_rows.push_back('{slafe_pkg::MODE_LINE, 9'h1FE, 8'hFF, 1'b1,
                             mk_out(1, slafe_pkg::ACK_WORD, 0, 8'h00, 0, 8'd2, 1, 0)});
        dir_rows.push_back('{slafe_pkg::MODE_LINE, 9'h15A, 8'h3C, 1'b0, '0});
        dir_rows.push_back('{slafe_pkg::MODE_READ, 9'h000, 8'h00, 1'b1,
                             mk_out(0, 9'h000, 1, 8'hFF, 0, 8'd2, 1, 0)});
        dir_rows.push_back('{slafe_pkg::MODE_WRITE, 9'h000, 8'h00, 1'b1,
                             mk_out(0, 9'h000, 0, 8'h00, 1, 8'd2, 0, 0)});
        dir_rows.push_back('{slafe_pkg::MODE_WRITE, 9'h000, 8'hFF, 1'b1,
                             mk_out(0, 9'h000, 0, 8'h00, 1, 8'd2, 0, 0)});
        dir_rows.push_back('{slafe_pkg::MODE_TICK, 9'h000, 8'h00, 1'b1,
                             mk_out(1, 9'h1FE, 0, 8'h00, 0, 8'd2, 0, 1)});
        dir_rows.push_back('{slafe_pkg::MODE_TICK, 9'h000, 8'h00, 1'b1,
                             mk_out(0, 9'h000, 0, 8'h00, 0, 8'd2, 0, 0)});
        dir_rows.push_back('{slafe_pkg::MODE_TICK, 9'h000, 8'h00, 1'b1,
                             mk_out(1, 9'h000, 0, 8'h00, 0, 8'd2, 1, 1)});
        dir_rows.push_back('{slafe_pkg::MODE_TICK, 9'h000, 8'h00, 1'b1,
                             mk_out(0, 9'h000, 0, 8'h00, 0, 8'd2, 1, 1)});
        dir_rows.push_back('{slafe_pkg::MODE_LINE, 9'h001, 8'h00, 1'b1,
                             mk_out(0, 9'h000, 0, 8'h00, 0, 8'd2, 1, 1)});
        dir_rows.push_back('{slafe_pkg::MODE_TICK, 9'h000, 8'h00, 1'b1,
                             mk_out(0, 9'h000, 0, 8'h00, 0, 8'd2, 1, 0)});
        dir_rows.push_back('{slafe_pkg::MODE_READ, 9'h000, 8'h00, 1'b0, '0});
        dir_rows.push_back('{slafe_pkg::MODE_READ, 9'h000, 8'h00, 1'b0, '0});
        dir_rows.push_back('{slafe_pkg::MODE_READ, 9'h000, 8'h00, 1'b1,
                             mk_out(0, 9'h000, 0, slafe_pkg::EMPTY_READ_BYTE, 0, 8'd0, 1, 0)});
        dir_rows.push_back('{slafe_pkg::MODE_WRITE, 9'h1FF, 8'hA5, 1'b0, '0});
        dir_rows.push_back('{slafe_pkg::MODE_TICK, 9'h1FF, 8'hFF, 1'b0, '0});
        dir_rows.push_back('{slafe_pkg::MODE_LINE, 9'h1FF, 8'h5A, 1'b0, '0});
        dir_rows.push_back('{slafe_pkg::MODE_TICK, 9'h000, 8'h00, 1'b0, '0});
        dir_rows.push_back('{slafe_pkg::MODE_READ, 9'h1FF, 8'hFF, 1'b0, '0});

        // Reset is held low at the start and released on a falling edge.
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            offer_word(row.m, row.lw, row.hb, row.typed, row.want);
        end

        // Random part. Mixed segments keep both rings moving; the burst segments
        // drive the receive ring past full, the transmit ring past full and the
        // acknowledge count into saturation.
        seg = 0;
        while (words_sent < dir_rows.size() + RANDOM_WORDS || seg <= LAST_SEG)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            if (seg == RX_FILL_SEG)
            begin
                // The result side holds off for a long stretch while data words keep
                // coming, so the block backs up onto its input.
                hold_off_req = 1'b1;
                len = 256 + $urandom_range(0, 6);
                for (k = 0; k < len; k++)
                begin
                    lw = 9'($urandom_range(0, 511));
                    lw[0] = 1'b0;
                    hb = 8'($urandom_range(0, 255));
                    offer_word(slafe_pkg::MODE_LINE, lw, hb, 1'b0, '0);
                end
                // Reads release the held acknowledge and make room again.
                for (k = 0; k < 20; k++)
                begin
                    lw = 9'($urandom_range(0, 511));
                    hb = 8'($urandom_range(0, 255));
                    offer_word(slafe_pkg::MODE_READ, lw, hb, 1'b0, '0);
                end
            end
            else if (seg == TX_FILL_SEG)
            begin
                // Writes past the point where the transmit ring is full; every later
                // write is turned away until a tick pops a byte.
                len = 256 + $urandom_range(0, 6);
                for (k = 0; k < len; k++)
                begin
                    lw = 9'($urandom_range(0, 511));
                    hb = 8'($urandom_range(0, 255));
                    offer_word(slafe_pkg::MODE_WRITE, lw, hb, 1'b0, '0);
                end
                // The word side pauses here until every due result has arrived.
                drain_results();
            end
            else if (seg == ACK_SEG)
            begin
                len = 258 + $urandom_range(0, 4);
                for (k = 0; k < len; k++)
                begin
                    lw = 9'($urandom_range(0, 511));
                    lw[0] = 1'b1;
                    hb = 8'($urandom_range(0, 255));
                    offer_word(slafe_pkg::MODE_LINE, lw, hb, 1'b0, '0);
                end
            end
            else
            begin
                len = $urandom_range(10, 20);
                repeat (len) offer_mixed();
            end
            seg++;
        end

        drain_results();
        repeat (SETTLE) @(posedge clk);
        if (fails == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
